@@ rtl/hav_pkg.sv @@
// Package for the haversine distance pipeline.
// Holds the fixed widths, scaling constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package hav_pkg;

	localparam int LAT_W = 24;
	localparam int LON_W = 25;
	localparam int IN_DATA_W = 104;
	localparam int OUT_W = 22;
	localparam int OUT_DATA_W = 24;

	localparam int ANG_W = 32;
	localparam int XY_W = 34;
	localparam int Z_W = 33;
	localparam int Q_W = 32;
	localparam int UQ_W = 31;
	localparam int SQ_IN_W = 61;
	localparam int SQ_BITS = 31;

	localparam int MAG_W = 25;
	localparam int QUO_W = 20;
	localparam int REM_W = 6;
	localparam int N2_W = 19;
	localparam int FRAC_SH = 13;
	localparam int DIV1_SH = 31;
	localparam int DIV2_SH = 25;
	localparam logic [25:0] DIV1_MUL = 26'd47721859;
	localparam logic [19:0] DIV2_MUL = 20'd745655;
	localparam logic [5:0] DIV_BY = 6'd45;
	localparam logic [4:0] ROUND_ADD = 5'd22;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [XY_W-1:0] ONE_XY = 34'sd1073741824;
	localparam logic signed [Z_W-1:0] ONE_Z = 33'sd1073741824;
	localparam logic [UQ_W-1:0] ONE_UQ = 31'd1073741824;
	localparam logic [23:0] MILES_SCALE = 24'd12735257;
	localparam logic [OUT_W-1:0] OUT_MAX = 22'h3FFFFF;

	function automatic logic [29:0] atan_val(input logic [4:0] idx);
		logic [29:0] r;
		case (idx)
			5'd0: r = 30'h20000000;
			5'd1: r = 30'h12E4051E;
			5'd2: r = 30'h09FB385B;
			5'd3: r = 30'h051111D4;
			5'd4: r = 30'h028B0D43;
			5'd5: r = 30'h0145D7E1;
			5'd6: r = 30'h00A2F61E;
			5'd7: r = 30'h00517C55;
			5'd8: r = 30'h0028BE53;
			5'd9: r = 30'h00145F2F;
			5'd10: r = 30'h000A2F98;
			5'd11: r = 30'h000517CC;
			5'd12: r = 30'h00028BE6;
			5'd13: r = 30'h000145F3;
			5'd14: r = 30'h0000A2FA;
			5'd15: r = 30'h0000517D;
			5'd16: r = 30'h000028BE;
			5'd17: r = 30'h0000145F;
			5'd18: r = 30'h00000A30;
			5'd19: r = 30'h00000518;
			5'd20: r = 30'h0000028C;
			5'd21: r = 30'h00000146;
			5'd22: r = 30'h000000A3;
			5'd23: r = 30'h00000051;
			5'd24: r = 30'h00000029;
			5'd25: r = 30'h00000014;
			5'd26: r = 30'h0000000A;
			5'd27: r = 30'h00000005;
			5'd28: r = 30'h00000003;
			5'd29: r = 30'h00000001;
			5'd30: r = 30'h00000001;
			default: r = 30'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/hav_deg2bang.sv @@
// Four-stage converter from fixed-point degrees to a 32-bit binary angle.
// Divides by 45 through two reciprocal multiplications; uses hav_pkg.
`default_nettype none
module hav_deg2bang #(
	parameter int IN_W = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic [IN_W-1:0]         angle,
	output logic                         out_valid,
	output logic [hav_pkg::ANG_W-1:0]    bang
);

	logic                         neg;
	logic [IN_W-1:0]              mag;
	logic [hav_pkg::MAG_W-1:0]    magx;
	logic                         v_s1, v_s2, v_s3, v_s4;
	logic                         neg_s1, neg_s2, neg_s3;
	logic [hav_pkg::MAG_W-1:0]    mag_s1;
	logic [50:0]                  p1_s1;
	logic [hav_pkg::QUO_W-1:0]    q1, q1_s2, q1_s3;
	logic [hav_pkg::MAG_W-1:0]    rem_full;
	logic [hav_pkg::N2_W-1:0]     n2, n2_s2;
	logic [38:0]                  p2_s3;
	logic [32:0]                  q;
	logic [hav_pkg::ANG_W-1:0]    q32, bang_s4;

	assign neg = angle[IN_W-1];
	assign mag = neg ? (~angle + IN_W'(1)) : angle;
	assign magx = hav_pkg::MAG_W'(mag);
	assign q1 = p1_s1[50:31];
	assign rem_full = mag_s1 - hav_pkg::MAG_W'(q1 * hav_pkg::DIV_BY);
	assign n2 = {rem_full[hav_pkg::REM_W-1:0], 13'd0} + hav_pkg::N2_W'(hav_pkg::ROUND_ADD);
	assign q = {q1_s3, 13'd0} + 33'(p2_s3[37:25]);
	assign q32 = q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg;
			mag_s1 <= magx;
			p1_s1 <= 51'(magx * hav_pkg::DIV1_MUL);
			neg_s2 <= neg_s1;
			q1_s2 <= q1;
			n2_s2 <= n2;
			neg_s3 <= neg_s2;
			q1_s3 <= q1_s2;
			p2_s3 <= 39'(n2_s2 * hav_pkg::DIV2_MUL);
			bang_s4 <= neg_s3 ? (~q32 + 32'd1) : q32;
		end
	end

	assign out_valid = v_s4;
	assign bang = bang_s4;

endmodule
`default_nettype wire

@@ rtl/hav_sincos.sv @@
// Rotation-mode CORDIC pipeline, one register stage per iteration.
// Returns clamped Q30 cosine and sine of a binary angle; uses hav_pkg.
`default_nettype none
module hav_sincos #(
	parameter int STEPS = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [hav_pkg::ANG_W-1:0]    ang,
	output logic                              out_valid,
	output logic signed [hav_pkg::Q_W-1:0]    cosv,
	output logic signed [hav_pkg::Q_W-1:0]    sinv
);

	logic signed [hav_pkg::XY_W-1:0] x_s [0:STEPS];
	logic signed [hav_pkg::XY_W-1:0] y_s [0:STEPS];
	logic signed [hav_pkg::Z_W-1:0]  z_s [0:STEPS];
	logic                            v_s [0:STEPS];
	logic                            n_s [0:STEPS];
	logic                            neg;
	logic [hav_pkg::ANG_W-1:0]       angf;
	logic signed [hav_pkg::Q_W-1:0]  cx, cy;
	logic signed [hav_pkg::Q_W-1:0]  cos_q, sin_q;
	logic                            vo_q;

	function automatic logic signed [hav_pkg::Q_W-1:0] clamp_q30(
		input logic signed [hav_pkg::XY_W-1:0] v
	);
		logic signed [hav_pkg::XY_W-1:0] r;
		if (v > hav_pkg::ONE_XY)
			r = hav_pkg::ONE_XY;
		else if (v < -hav_pkg::ONE_XY)
			r = -hav_pkg::ONE_XY;
		else
			r = v;
		return r[hav_pkg::Q_W-1:0];
	endfunction

	assign neg = ang[31] ^ ang[30];
	assign angf = neg ? {~ang[31], ang[30:0]} : ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= hav_pkg::CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= $signed({angf[31], angf});
			n_s[0] <= neg;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [hav_pkg::XY_W-1:0] dx, dy;
		logic signed [hav_pkg::Z_W-1:0]  da;
		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;
		assign da = $signed(hav_pkg::Z_W'(hav_pkg::atan_val(5'(i))));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1] <= n_s[i];
				if (!z_s[i][hav_pkg::Z_W-1]) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - da;
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + da;
				end
			end
		end
	end

	assign cx = clamp_q30(x_s[STEPS]);
	assign cy = clamp_q30(y_s[STEPS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= n_s[STEPS] ? -cx : cx;
			sin_q <= n_s[STEPS] ? -cy : cy;
		end
	end

	assign out_valid = vo_q;
	assign cosv = cos_q;
	assign sinv = sin_q;

endmodule
`default_nettype wire

@@ rtl/hav_isqrt.sv @@
// Pipelined floor square root of a 61-bit value, one result bit per stage.
// Produces a 31-bit root after 32 register stages; uses hav_pkg.
`default_nettype none
module hav_isqrt (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic [hav_pkg::SQ_IN_W-1:0]    val,
	output logic                                out_valid,
	output logic [hav_pkg::UQ_W-1:0]            root
);

	localparam int N = hav_pkg::SQ_BITS;
	localparam int W = hav_pkg::SQ_IN_W;

	logic [W-1:0]                 rem_s  [0:N];
	logic [hav_pkg::UQ_W-1:0]     root_s [0:N];
	logic                         v_s    [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= val;
			root_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_bit
		localparam int K = N - 1 - j;
		logic [W:0] trial;
		assign trial = ((W+1)'(root_s[j]) << (K + 1)) | ((W+1)'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_s[j]} >= trial) begin
					rem_s[j+1] <= rem_s[j] - trial[W-1:0];
					root_s[j+1] <= root_s[j] | (hav_pkg::UQ_W'(1) << K);
				end else begin
					rem_s[j+1] <= rem_s[j];
					root_s[j+1] <= root_s[j];
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign root = root_s[N];

endmodule
`default_nettype wire

@@ rtl/hav_vector.sv @@
// Vectoring-mode CORDIC pipeline giving the half central angle in Q30.
// One register stage per iteration plus a clamp stage; uses hav_pkg.
`default_nettype none
module hav_vector #(
	parameter int STEPS = 24
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [hav_pkg::UQ_W-1:0]   xin,
	input  wire logic [hav_pkg::UQ_W-1:0]   yin,
	output logic                            out_valid,
	output logic [hav_pkg::UQ_W-1:0]        angle
);

	logic signed [hav_pkg::XY_W-1:0] x_s [0:STEPS];
	logic signed [hav_pkg::XY_W-1:0] y_s [0:STEPS];
	logic signed [hav_pkg::Z_W-1:0]  z_s [0:STEPS];
	logic                            v_s [0:STEPS];
	logic signed [hav_pkg::Z_W-1:0]  zf;
	logic [hav_pkg::UQ_W-1:0]        ang_q;
	logic                            vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= $signed(hav_pkg::XY_W'(xin));
			y_s[0] <= $signed(hav_pkg::XY_W'(yin));
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [hav_pkg::XY_W-1:0] dx, dy;
		logic signed [hav_pkg::Z_W-1:0]  da;
		logic                            pos;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign da = $signed(hav_pkg::Z_W'(hav_pkg::atan_val(5'(i))));
		assign pos = !y_s[i][hav_pkg::XY_W-1] && (y_s[i] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (pos) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + da;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - da;
				end
			end
		end
	end

	assign zf = z_s[STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zf[hav_pkg::Z_W-1])
				ang_q <= '0;
			else if (zf > hav_pkg::ONE_Z)
				ang_q <= hav_pkg::ONE_UQ;
			else
				ang_q <= zf[hav_pkg::UQ_W-1:0];
		end
	end

	assign out_valid = vo_q;
	assign angle = ang_q;

endmodule
`default_nettype wire

@@ rtl/haversine_distance.sv @@
// Haversine great circle distance: top level of the pipeline.
// Depends on hav_pkg, hav_deg2bang, hav_sincos, hav_isqrt and hav_vector.
//
// A beat on the s_ channel carries two points as latitude and longitude in
// signed degrees with 16 fraction bits. Each beat yields exactly one beat on
// the m_ channel: the great circle distance in miles with 8 fraction bits,
// saturating at the top of the field. Results leave in input order.
// The pipeline takes one beat per cycle while the receiver does not stall it.
// An accepted input beat passes through two CORDIC chains of one iteration per
// stage and a square root of one bit per stage before its result reaches m_tvalid.
// The whole pipeline advances when the output register is empty or its beat
// is taken; while the receiver stalls with a result waiting, s_tready is low
// and every stage holds, so nothing is dropped or repeated.
// Reset clears all valid bits; the first beat can enter the cycle after
// arst_n is released.
`default_nettype none
module haversine_distance #(
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// first_latitude, first_longitude, second_latitude, second_longitude
	input  wire logic [hav_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// distance_miles
	output logic [hav_pkg::OUT_DATA_W-1:0]           m_tdata
);

	logic                             en;
	logic [3:0]                       bv;
	logic [hav_pkg::ANG_W-1:0]        lat1, lon1, lat2, lon2, dlat, dlon;
	logic                             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [hav_pkg::ANG_W-1:0]        hlat_s1, hlon_s1, lat1_s1, lat2_s1;
	logic [3:0]                       cv;
	logic signed [hav_pkg::Q_W-1:0]   s1, s2, cl1, cl2;
	logic signed [63:0]               ps1, ps2, pcc, pt;
	logic [hav_pkg::UQ_W-1:0]         sq1_s2, sq2_s2, sq1_s3;
	logic signed [hav_pkg::Q_W-1:0]   cc_s2, t_s3;
	logic signed [hav_pkg::Z_W-1:0]   asum;
	logic [hav_pkg::UQ_W-1:0]         a_s4, am_s4;
	logic [1:0]                       rv;
	logic [hav_pkg::UQ_W-1:0]         ry, rx;
	logic                             zv;
	logic [hav_pkg::UQ_W-1:0]         zang;
	logic [54:0]                      prod_s5;
	logic [55:0]                      rnd;
	logic [hav_pkg::OUT_W-1:0]        miles_s6;
	logic                             mv_q;
	logic [hav_pkg::OUT_W-1:0]        md_q;

	assign en = !mv_q || m_tready;
	assign s_tready = en;

	hav_deg2bang #(.IN_W(hav_pkg::LAT_W)) u_lat1 (
		.clk, .arst_n, .en, .in_valid(s_tvalid && en),
		.angle(s_tdata[23:0]), .out_valid(bv[0]), .bang(lat1)
	);
	hav_deg2bang #(.IN_W(hav_pkg::LON_W)) u_lon1 (
		.clk, .arst_n, .en, .in_valid(s_tvalid && en),
		.angle(s_tdata[48:24]), .out_valid(bv[1]), .bang(lon1)
	);
	hav_deg2bang #(.IN_W(hav_pkg::LAT_W)) u_lat2 (
		.clk, .arst_n, .en, .in_valid(s_tvalid && en),
		.angle(s_tdata[72:49]), .out_valid(bv[2]), .bang(lat2)
	);
	hav_deg2bang #(.IN_W(hav_pkg::LON_W)) u_lon2 (
		.clk, .arst_n, .en, .in_valid(s_tvalid && en),
		.angle(s_tdata[97:73]), .out_valid(bv[3]), .bang(lon2)
	);

	assign dlat = lat2 - lat1;
	assign dlon = lon2 - lon1;

	hav_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlat (
		.clk, .arst_n, .en, .in_valid(v_s1), .ang(hlat_s1),
		.out_valid(cv[0]), .cosv(), .sinv(s1)
	);
	hav_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlon (
		.clk, .arst_n, .en, .in_valid(v_s1), .ang(hlon_s1),
		.out_valid(cv[1]), .cosv(), .sinv(s2)
	);
	hav_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat1 (
		.clk, .arst_n, .en, .in_valid(v_s1), .ang(lat1_s1),
		.out_valid(cv[2]), .cosv(cl1), .sinv()
	);
	hav_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat2 (
		.clk, .arst_n, .en, .in_valid(v_s1), .ang(lat2_s1),
		.out_valid(cv[3]), .cosv(cl2), .sinv()
	);

	assign ps1 = s1 * s1;
	assign ps2 = s2 * s2;
	assign pcc = cl1 * cl2;
	assign pt = cc_s2 * $signed({1'b0, sq2_s2});
	assign asum = $signed({2'b00, sq1_s3}) + $signed({t_s3[hav_pkg::Q_W-1], t_s3});

	hav_isqrt u_sqrt_a (
		.clk, .arst_n, .en, .in_valid(v_s4), .val({a_s4, 30'd0}),
		.out_valid(rv[0]), .root(ry)
	);
	hav_isqrt u_sqrt_am (
		.clk, .arst_n, .en, .in_valid(v_s4), .val({am_s4, 30'd0}),
		.out_valid(rv[1]), .root(rx)
	);

	hav_vector #(.STEPS(CORDIC_STEPS)) u_vec (
		.clk, .arst_n, .en, .in_valid(rv[0] && rv[1]), .xin(rx), .yin(ry),
		.out_valid(zv), .angle(zang)
	);

	assign rnd = {1'b0, prod_s5} + 56'h80000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			mv_q <= 1'b0;
		end else if (en) begin
			v_s1 <= &bv;
			v_s2 <= &cv;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= zv;
			v_s6 <= v_s5;
			mv_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hlat_s1 <= {dlat[31], dlat[31:1]};
			hlon_s1 <= {dlon[31], dlon[31:1]};
			lat1_s1 <= lat1;
			lat2_s1 <= lat2;
			sq1_s2 <= ps1[60:30];
			sq2_s2 <= ps2[60:30];
			cc_s2 <= pcc[61:30];
			sq1_s3 <= sq1_s2;
			t_s3 <= pt[61:30];
			if (asum[hav_pkg::Z_W-1]) begin
				a_s4 <= '0;
				am_s4 <= hav_pkg::ONE_UQ;
			end else if (asum > hav_pkg::ONE_Z) begin
				a_s4 <= hav_pkg::ONE_UQ;
				am_s4 <= '0;
			end else begin
				a_s4 <= asum[hav_pkg::UQ_W-1:0];
				am_s4 <= hav_pkg::ONE_UQ - asum[hav_pkg::UQ_W-1:0];
			end
			prod_s5 <= 55'(zang * hav_pkg::MILES_SCALE);
			miles_s6 <= (rnd[55:54] != 2'b00) ? hav_pkg::OUT_MAX : rnd[53:32];
			md_q <= miles_s6;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata = {2'b00, md_q};

endmodule
`default_nettype wire

@@ sim/tb_haversine_distance.sv @@
// Self-checking testbench for the haversine_distance pipeline.
// Depends on hav_pkg and the haversine_distance RTL; it predicts every distance
// in a fixed-point model of its own and checks each output beat in order.
`default_nettype none
module tb_haversine_distance;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAT_W = hav_pkg::LAT_W;
	localparam int LON_W = hav_pkg::LON_W;
	localparam int IN_DATA_W = hav_pkg::IN_DATA_W;
	localparam int OUT_W = hav_pkg::OUT_W;
	localparam int OUT_DATA_W = hav_pkg::OUT_DATA_W;

	localparam int STEPS = 24;
	localparam int LATENCY = 2 * STEPS + 47;
	localparam int STALL_LIMIT = 4000;
	localparam longint Q30 = 64'sd1 << 30;
	localparam longint GAIN = 64'sd652032874;
	localparam longint MI_SCALE = 64'sd12735257;
	localparam longint DIST_MAX = 64'sd4194303;
	localparam int LAT_MAX = 5898240;
	localparam int LON_MAX = 11796480;

	localparam longint ARCTAN [32] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
		64'h00000001, 64'h00000000
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	logic [OUT_W-1:0] distance_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	haversine_distance #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] degrees_to_bangle(input longint deg);
		longint unsigned mag, q;
		mag = (deg < 0) ? -deg : deg;
		q = (mag * 8192 + 22) / 45;
		return (deg < 0) ? 32'(64'd0 - q) : 32'(q);
	endfunction

	function automatic logic [31:0] half_angle(input logic [31:0] b1, input logic [31:0] b2);
		logic [31:0] d;
		d = b2 - b1;
		return {d[31], d[31:1]};
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic rotate_sin_cos(input logic [31:0] ang, output longint c, output longint s);
		logic flip;
		longint x, y, z, dx, dy;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		if (flip) begin
			ang = ang + 32'h80000000;
		end
		x = GAIN;
		y = 0;
		z = $signed(ang);
		for (int i = 0; i < STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN[i];
			end
		end
		x = clamp(x, -Q30, Q30);
		y = clamp(y, -Q30, Q30);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	task automatic predict_distance(input logic signed [LAT_W-1:0] lat1,
			input logic signed [LON_W-1:0] lon1, input logic signed [LAT_W-1:0] lat2,
			input logic signed [LON_W-1:0] lon2, output logic [OUT_W-1:0] miles_q8);
		logic [31:0] b_lat1, b_lon1, b_lat2, b_lon2;
		longint c1, s1, c2, s2, cl1, sl1, cl2, sl2, hav, x, y, z, dx, dy, miles;
		b_lat1 = degrees_to_bangle(longint'(lat1));
		b_lon1 = degrees_to_bangle(longint'(lon1));
		b_lat2 = degrees_to_bangle(longint'(lat2));
		b_lon2 = degrees_to_bangle(longint'(lon2));
		rotate_sin_cos(half_angle(b_lat1, b_lat2), c1, s1);
		rotate_sin_cos(half_angle(b_lon1, b_lon2), c2, s2);
		rotate_sin_cos(b_lat1, cl1, sl1);
		rotate_sin_cos(b_lat2, cl2, sl2);
		hav = ((s1 * s1) >>> 30) + ((((cl1 * cl2) >>> 30) * ((s2 * s2) >>> 30)) >>> 30);
		hav = clamp(hav, 0, Q30);
		x = int_sqrt(longint'(Q30 - hav) << 30);
		y = int_sqrt(longint'(hav) << 30);
		z = 0;
		for (int i = 0; i < STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ARCTAN[i];
			end else begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end
		end
		z = clamp(z, 0, Q30);
		miles = (z * MI_SCALE + (64'sd1 << 31)) >>> 32;
		if (miles > DIST_MAX) begin
			miles = DIST_MAX;
		end
		miles_q8 = OUT_W'(miles);
	endtask

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	// The valid line stays high between back-to-back beats; it only drops for idle cycles.
	task automatic send_pair(input logic signed [LAT_W-1:0] lat1,
			input logic signed [LON_W-1:0] lon1, input logic signed [LAT_W-1:0] lat2,
			input logic signed [LON_W-1:0] lon2);
		logic [OUT_W-1:0] want;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= {IN_DATA_W{1'b1}};
			@(posedge clk);
		end
		s_tdata <= IN_DATA_W'({lon2, lat2, lon1, lat1});
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_distance(lat1, lon1, lat2, lon2, want);
		distance_q.push_back(want);
	endtask

	task automatic send_random_pair();
		int kind;
		kind = $urandom_range(9);
		if (kind < 8) begin
			send_pair(LAT_W'($urandom_range(2 * LAT_MAX) - LAT_MAX),
				LON_W'($urandom_range(2 * LON_MAX) - LON_MAX),
				LAT_W'($urandom_range(2 * LAT_MAX) - LAT_MAX),
				LON_W'($urandom_range(2 * LON_MAX) - LON_MAX));
		end else begin
			send_pair(LAT_W'($urandom), LON_W'($urandom), LAT_W'($urandom), LON_W'($urandom));
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (distance_q.size() == 0) begin
				report_mismatch("unexpected beat", -1, m_tdata);
			end else begin
				if (m_tdata[OUT_W-1:0] !== distance_q[0]) begin
					report_mismatch("distance_miles", distance_q[0], m_tdata[OUT_W-1:0]);
				end
				if (m_tdata[OUT_DATA_W-1:OUT_W] !== '0) begin
					report_mismatch("tdata padding", 0, m_tdata[OUT_DATA_W-1:OUT_W]);
				end
				void'(distance_q.pop_front());
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_directed();
		send_pair(0, 0, 0, 0);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		send_pair(0, 0, 0, LON_MAX);
		send_pair(0, -LON_MAX, 0, LON_MAX);
		send_pair(0, 0, 0, 11796479);
		send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
		send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
		send_pair(2621440, 0, -2621440, LON_MAX);
		send_pair(3342090, -7765470, 2683420, -8064000);
		send_pair(-8388608, -16777216, 8388607, 16777215);
		send_pair(8388607, 16777215, -8388608, -16777216);
		send_pair(8000000, 0, -8000000, 0);
		send_pair(0, 16000000, 0, -16000000);
		send_pair(1, 1, -1, -1);
		send_pair(-1, -1, -1, -1);
		send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_random_pair();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 400;
		repeat (300) send_random_pair();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 0, 385);
		test_random(53, 0, 385);
		test_random(0, 53, 385);
		test_random(29, 29, 385);
		test_backpressure();
		s_tvalid <= 1'b0;
		while (distance_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
rtl/hav_pkg.sv
rtl/hav_deg2bang.sv
rtl/hav_sincos.sv
rtl/hav_isqrt.sv
rtl/hav_vector.sv
rtl/haversine_distance.sv
sim/tb_haversine_distance.sv
